// ----- src/imaenc_pkg.sv -----
`timescale 1ns / 1ps

package imaenc_pkg;

    localparam int FRAME_LEN = 320;
    localparam int POS_W = $clog2(FRAME_LEN);
    localparam int MAX_INDEX = 88;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [31:0] data;
        logic [1:0]  last_sel;
        logic        last;
    } entry_t;

    localparam logic [14:0] STEP_TABLE [0:88] = '{
        15'd7, 15'd8, 15'd9, 15'd10, 15'd11, 15'd12, 15'd13, 15'd14, 15'd16, 15'd17,
        15'd19, 15'd21, 15'd23, 15'd25, 15'd28, 15'd31, 15'd34, 15'd37, 15'd41, 15'd45,
        15'd50, 15'd55, 15'd60, 15'd66, 15'd73, 15'd80, 15'd88, 15'd97, 15'd107, 15'd118,
        15'd130, 15'd143, 15'd157, 15'd173, 15'd190, 15'd209, 15'd230, 15'd253, 15'd279,
        15'd307, 15'd337, 15'd371, 15'd408, 15'd449, 15'd494, 15'd544, 15'd598, 15'd658,
        15'd724, 15'd796, 15'd876, 15'd963, 15'd1060, 15'd1166, 15'd1282, 15'd1411,
        15'd1552, 15'd1707, 15'd1878, 15'd2066, 15'd2272, 15'd2499, 15'd2749, 15'd3024,
        15'd3327, 15'd3660, 15'd4026, 15'd4428, 15'd4871, 15'd5358, 15'd5894, 15'd6484,
        15'd7132, 15'd7845, 15'd8630, 15'd9493, 15'd10442, 15'd11487, 15'd12635,
        15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350, 15'd22385, 15'd24623,
        15'd27086, 15'd29794, 15'd32767
    };

    function automatic logic [14:0] step_size(input logic [6:0] idx);
        logic [14:0] result;
        if (idx > 7'(MAX_INDEX))
        begin
            result = STEP_TABLE[MAX_INDEX];
        end
        else
        begin
            result = STEP_TABLE[idx];
        end
        return result;
    endfunction

    function automatic logic signed [7:0] index_adjust(input logic [2:0] mbits);
        logic signed [7:0] result;
        case (mbits)
            3'd4:    result = 8'sd2;
            3'd5:    result = 8'sd4;
            3'd6:    result = 8'sd6;
            3'd7:    result = 8'sd8;
            default: result = -8'sd1;
        endcase
        return result;
    endfunction

endpackage

// ----- src/imaenc_core.sv -----
`timescale 1ns / 1ps

module imaenc_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [15:0]         in_sample,
    output logic                push,
    output imaenc_pkg::entry_t  push_entry,
    input  logic                space
);

    logic                           s_valid_reg, s_valid_next;
    logic [15:0]                    s_reg;
    logic [15:0]                    pred_reg, pred_next;
    logic [6:0]                     index_reg, index_next;
    logic [imaenc_pkg::POS_W-1:0]   pos_reg, pos_next;
    logic [3:0]                     held_reg, held_next;

    logic [14:0]        step;
    logic [16:0]        diff;
    logic               neg;
    logic [16:0]        mag_full;
    logic [15:0]        m0, m1, m2;
    logic               b2, b1, b0;
    logic [16:0]        dq;
    logic signed [17:0] p_sum;
    logic signed [7:0]  idx_sum;
    logic [3:0]         code;
    logic [15:0]        pred_new;
    logic [6:0]         index_new;
    logic               pos_last;
    logic               needs_push;
    logic               advance;
    logic               fire;

    // quantize the difference against the current step and work out the updated predictor and step index
    always_comb
    begin
        step     = imaenc_pkg::step_size(index_reg);
        diff     = {s_reg[15], s_reg} - {pred_reg[15], pred_reg};
        neg      = diff[16];
        mag_full = neg ? 17'(-diff) : diff;
        m0       = mag_full[15:0];
        b2       = m0 >= {1'b0, step};
        m1       = b2 ? m0 - {1'b0, step} : m0;
        b1       = m1 >= {2'b00, step[14:1]};
        m2       = b1 ? m1 - {2'b00, step[14:1]} : m1;
        b0       = m2 >= {3'b000, step[14:2]};
        code     = {neg, b2, b1, b0};

        dq = {5'd0, step[14:3]}
           + (b2 ? {2'b00, step} : 17'd0)
           + (b1 ? {3'b000, step[14:1]} : 17'd0)
           + (b0 ? {4'b0000, step[14:2]} : 17'd0);
        p_sum = neg ? $signed({{2{pred_reg[15]}}, pred_reg} - {1'b0, dq})
                    : $signed({{2{pred_reg[15]}}, pred_reg} + {1'b0, dq});
        if (p_sum > 18'sd32767)
        begin
            pred_new = 16'h7fff;
        end
        else if (p_sum < -18'sd32768)
        begin
            pred_new = 16'h8000;
        end
        else
        begin
            pred_new = p_sum[15:0];
        end

        idx_sum = $signed({1'b0, index_reg}) + imaenc_pkg::index_adjust(code[2:0]);
        if (idx_sum < 8'sd0)
        begin
            index_new = 7'd0;
        end
        else if (idx_sum > 8'(imaenc_pkg::MAX_INDEX))
        begin
            index_new = 7'(imaenc_pkg::MAX_INDEX);
        end
        else
        begin
            index_new = idx_sum[6:0];
        end
    end

    // frame position, handshake, byte grouping and state update
    always_comb
    begin
        pos_last   = pos_reg == imaenc_pkg::POS_W'(imaenc_pkg::FRAME_LEN - 1);
        needs_push = (pos_reg == '0) || pos_reg[0] || pos_last;
        advance    = !needs_push || space;
        fire       = s_valid_reg && advance;
        in_ready   = !s_valid_reg || advance;
        push       = fire && needs_push;

        if (pos_reg == '0)
        begin
            push_entry.data     = {8'h00, {1'b0, index_reg}, pred_reg[15:8], pred_reg[7:0]};
            push_entry.last_sel = 2'd3;
            push_entry.last     = 1'b0;
        end
        else if (pos_reg[0])
        begin
            push_entry.data     = {24'h000000, held_reg, code};
            push_entry.last_sel = 2'd0;
            push_entry.last     = pos_last;
        end
        else
        begin
            push_entry.data     = {24'h000000, code, 4'h0};
            push_entry.last_sel = 2'd0;
            push_entry.last     = 1'b1;
        end

        s_valid_next = in_ready ? in_valid : s_valid_reg;
        pred_next    = fire ? pred_new : pred_reg;
        index_next   = fire ? index_new : index_reg;
        held_next    = (fire && !pos_reg[0]) ? code : held_reg;
        if (fire)
        begin
            pos_next = pos_last ? '0 : pos_reg + 1'b1;
        end
        else
        begin
            pos_next = pos_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg <= 1'b0;
            pred_reg    <= '0;
            index_reg   <= '0;
            pos_reg     <= '0;
            held_reg    <= '0;
        end
        else
        begin
            s_valid_reg <= s_valid_next;
            pred_reg    <= pred_next;
            index_reg   <= index_next;
            pos_reg     <= pos_next;
            held_reg    <= held_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s_reg <= in_sample;
        end
    end

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        index_reg <= 7'(imaenc_pkg::MAX_INDEX))
        else $error("step index out of range");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg < imaenc_pkg::POS_W'(imaenc_pkg::FRAME_LEN))
        else $error("frame position out of range");

    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(pred_reg) && $stable(index_reg) && $stable(pos_reg))
        else $error("encoder state moved without a sample");

endmodule

// ----- src/imaenc_fifo.sv -----
`timescale 1ns / 1ps

module imaenc_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  imaenc_pkg::entry_t  push_entry,
    output logic                space,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          out_byte,
    output logic                out_last
);

    imaenc_pkg::entry_t                 entries_reg [imaenc_pkg::FIFO_DEPTH];
    logic [imaenc_pkg::FIFO_AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [imaenc_pkg::FIFO_AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [imaenc_pkg::FIFO_CW-1:0]     count_reg, count_next;
    logic [1:0]                         sel_reg, sel_next;

    imaenc_pkg::entry_t head;
    logic               pop_byte;
    logic               pop_entry;

    always_comb
    begin
        head      = entries_reg[rd_ptr_reg];
        space     = count_reg != imaenc_pkg::FIFO_CW'(imaenc_pkg::FIFO_DEPTH);
        out_valid = count_reg != '0;
        case (sel_reg)
            2'd0:    out_byte = head.data[7:0];
            2'd1:    out_byte = head.data[15:8];
            2'd2:    out_byte = head.data[23:16];
            default: out_byte = head.data[31:24];
        endcase
        out_last  = head.last && (sel_reg == head.last_sel);
        pop_byte  = out_valid && out_ready;
        pop_entry = pop_byte && (sel_reg == head.last_sel);

        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop_entry ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        if (pop_entry)
        begin
            sel_next = 2'd0;
        end
        else if (pop_byte)
        begin
            sel_next = sel_reg + 1'b1;
        end
        else
        begin
            sel_next = sel_reg;
        end
        case ({push, pop_entry})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            sel_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            sel_reg    <= sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> space)
        else $error("entry written into a full queue");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= imaenc_pkg::FIFO_CW'(imaenc_pkg::FIFO_DEPTH))
        else $error("queue count out of range");

    a_sel_idle: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == '0 |-> sel_reg == 2'd0)
        else $error("byte select left over on an empty queue");

endmodule

// ----- src/ima_adpcm_frame_encoder_top.sv -----
`timescale 1ns / 1ps

// channel  dir  fields (lowest bit up)               accepted when
// s_*      in   tdata: sample[15:0] signed           s_tvalid && s_tready
// m_*      out  tdata: out_byte[7:0], tlast: last    m_tvalid && m_tready
//
// one sample a cycle enters a register while s_tready is high, is encoded against
// the running state and lands in a 4-entry queue: frame position 0 as a 4-byte
// header, each odd position as a byte of two codes, other positions as nothing
// with m_tready high the queue drains one byte a cycle, so no sample waits
// s_tready drops only while the queue is full and the held sample must emit bytes
// reset clears predictor, step index, frame position and queue at once

module ima_adpcm_frame_encoder_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // sample
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte
    output logic        m_tlast
);

    logic               push;
    imaenc_pkg::entry_t push_entry;
    logic               space;

    imaenc_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_sample  (s_tdata),
        .push       (push),
        .push_entry (push_entry),
        .space      (space)
    );

    imaenc_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .space      (space),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_byte   (m_tdata),
        .out_last   (m_tlast)
    );

endmodule
